@@ src/uart_ring_buffers_realtime_intercept_macros.svh @@
// Assertion helpers used by the top-level ring buffer RTL file.
`ifndef UART_RING_BUFFERS_REALTIME_INTERCEPT_MACROS_SVH
`define UART_RING_BUFFERS_REALTIME_INTERCEPT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define URBRI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define URBRI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/urbri_pkg.sv @@
`timescale 1ns / 1ps

package urbri_pkg;

  localparam int RX_DEPTH = 128;
  localparam int TX_DEPTH = 64;
  localparam int RX_PW    = $clog2(RX_DEPTH);
  localparam int TX_PW    = $clog2(TX_DEPTH);
  localparam int RX_CW    = 7;
  localparam int TX_CW    = 6;
  localparam int BYTE_W   = 8;
  localparam int CFG_IW   = 3;

  typedef enum logic [2:0] {
    CMD_LINE_RX   = 3'd0,
    CMD_HOST_READ = 3'd1,
    CMD_HOST_WR   = 3'd2,
    CMD_TX_READY  = 3'd3,
    CMD_RX_FLUSH  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_STATUS = 3'd1,
    EV_CYCLE  = 3'd2,
    EV_HOLD   = 3'd3,
    EV_DOOR   = 3'd4,
    EV_RESET  = 3'd5
  } rt_event_t;

  typedef enum logic [2:0] {
    REG_STATUS = 3'd0,
    REG_CYCLE  = 3'd1,
    REG_HOLD   = 3'd2,
    REG_DOOR   = 3'd3,
    REG_RESET  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] status_code;
    logic [BYTE_W-1:0] cycle_code;
    logic [BYTE_W-1:0] hold_code;
    logic [BYTE_W-1:0] door_code;
    logic [BYTE_W-1:0] reset_code;
  } rt_codes_t;

endpackage

@@ src/urbri_ram.sv @@
`timescale 1ns / 1ps

module urbri_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/urbri_match.sv @@
`timescale 1ns / 1ps

module urbri_match (
  input  logic [7:0]          data,
  input  urbri_pkg::rt_codes_t codes,
  output urbri_pkg::rt_event_t ev
);
  import urbri_pkg::*;

  // first match wins: status, cycle start, feed hold, door, reset
  always_comb begin
    if (data == codes.status_code) begin
      ev = EV_STATUS;
    end else if (data == codes.cycle_code) begin
      ev = EV_CYCLE;
    end else if (data == codes.hold_code) begin
      ev = EV_HOLD;
    end else if (data == codes.door_code) begin
      ev = EV_DOOR;
    end else if (data == codes.reset_code) begin
      ev = EV_RESET;
    end else begin
      ev = EV_NONE;
    end
  end

endmodule

@@ src/uart_ring_buffers_realtime_intercept.sv @@
`timescale 1ns / 1ps

// Receive and transmit byte rings with realtime command intercept. One request is taken per
// clock while out_ready is high; its result appears on the out_ channel in the next cycle, and
// a new request is taken in the same cycle that the previous result is taken. Each request
// does at most one access to each ring's RAM, whose registered read port supplies rx_byte and
// tx_byte with the result. A ring of depth N holds at most N-1 bytes. The rings need no
// clearing after reset: only written entries are ever read.
module uart_ring_buffers_realtime_intercept (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_cmd,
  input  logic [7:0] in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_rx_byte,
  output logic       out_rx_valid,
  output logic [2:0] out_rt_event,
  output logic       out_rx_dropped,
  output logic [7:0] out_tx_byte,
  output logic       out_tx_valid,
  output logic       out_tx_accepted,
  output logic       out_tx_idle,
  output logic [6:0] out_rx_count,
  output logic [5:0] out_tx_count,
  input  logic       cfg_we,
  input  logic [urbri_pkg::CFG_IW-1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);
  import urbri_pkg::*;
`include "uart_ring_buffers_realtime_intercept_macros.svh"

  rt_codes_t codes_r;
  rt_event_t ev;

  logic [RX_PW-1:0] rx_head_r, rx_tail_r, rx_head_nxt, rx_tail_nxt, rx_head_inc, rx_tail_inc;
  logic [TX_PW-1:0] tx_head_r, tx_tail_r, tx_head_nxt, tx_tail_nxt, tx_head_inc, tx_tail_inc;
  logic             rx_empty, rx_full, tx_empty, tx_full;
  logic             acc;
  logic             rx_we, rx_re, tx_we, tx_re;
  logic [7:0]       rx_rdata, tx_rdata;
  logic [RX_PW:0]   rx_diff;
  logic [TX_PW:0]   tx_diff;

  logic             out_valid_r, out_valid_nxt;
  logic             rx_valid_r, rx_dropped_r, tx_valid_r, tx_accepted_r, tx_idle_r;
  rt_event_t        ev_r, ev_nxt;
  logic             rx_dropped_nxt, tx_accepted_nxt;
  logic [RX_CW-1:0] rx_count_r;
  logic [TX_CW-1:0] tx_count_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r.status_code <= 8'd63;
      codes_r.cycle_code  <= 8'd126;
      codes_r.hold_code   <= 8'd33;
      codes_r.door_code   <= 8'd64;
      codes_r.reset_code  <= 8'd24;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STATUS: codes_r.status_code <= cfg_wdata;
        REG_CYCLE:  codes_r.cycle_code  <= cfg_wdata;
        REG_HOLD:   codes_r.hold_code   <= cfg_wdata;
        REG_DOOR:   codes_r.door_code   <= cfg_wdata;
        REG_RESET:  codes_r.reset_code  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  urbri_match u_match (
    .data  (in_data),
    .codes (codes_r),
    .ev    (ev)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;

  assign rx_head_inc = (rx_head_r == RX_PW'(RX_DEPTH - 1)) ? '0 : rx_head_r + 1'b1;
  assign rx_tail_inc = (rx_tail_r == RX_PW'(RX_DEPTH - 1)) ? '0 : rx_tail_r + 1'b1;
  assign tx_head_inc = (tx_head_r == TX_PW'(TX_DEPTH - 1)) ? '0 : tx_head_r + 1'b1;
  assign tx_tail_inc = (tx_tail_r == TX_PW'(TX_DEPTH - 1)) ? '0 : tx_tail_r + 1'b1;
  assign rx_empty    = rx_head_r == rx_tail_r;
  assign rx_full     = rx_head_inc == rx_tail_r;
  assign tx_empty    = tx_head_r == tx_tail_r;
  assign tx_full     = tx_head_inc == tx_tail_r;

  always_comb begin
    rx_we           = 1'b0;
    rx_re           = 1'b0;
    tx_we           = 1'b0;
    tx_re           = 1'b0;
    ev_nxt          = EV_NONE;
    rx_dropped_nxt  = 1'b0;
    tx_accepted_nxt = 1'b0;
    rx_head_nxt     = rx_head_r;
    rx_tail_nxt     = rx_tail_r;
    tx_head_nxt     = tx_head_r;
    tx_tail_nxt     = tx_tail_r;
    case (in_cmd)
      CMD_LINE_RX: begin
        ev_nxt = ev;
        if (ev == EV_NONE) begin
          if (rx_full) begin
            rx_dropped_nxt = 1'b1;
          end else begin
            rx_we       = acc;
            rx_head_nxt = rx_head_inc;
          end
        end
      end
      CMD_HOST_READ: begin
        if (!rx_empty) begin
          rx_re       = acc;
          rx_tail_nxt = rx_tail_inc;
        end
      end
      CMD_HOST_WR: begin
        if (!tx_full) begin
          tx_we           = acc;
          tx_head_nxt     = tx_head_inc;
          tx_accepted_nxt = 1'b1;
        end
      end
      CMD_TX_READY: begin
        if (!tx_empty) begin
          tx_re       = acc;
          tx_tail_nxt = tx_tail_inc;
        end
      end
      CMD_RX_FLUSH: begin
        rx_tail_nxt = rx_head_r;
      end
      default: ;
    endcase
  end

  // fill counts from the updated pointers
  always_comb begin
    rx_diff = {1'b0, rx_head_nxt} - {1'b0, rx_tail_nxt};
    if (rx_head_nxt < rx_tail_nxt) begin
      rx_diff = rx_diff + (RX_PW + 1)'(RX_DEPTH);
    end
    tx_diff = {1'b0, tx_head_nxt} - {1'b0, tx_tail_nxt};
    if (tx_head_nxt < tx_tail_nxt) begin
      tx_diff = tx_diff + (TX_PW + 1)'(TX_DEPTH);
    end
  end

  urbri_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_head_r),
    .wdata (in_data),
    .re    (rx_re),
    .raddr (rx_tail_r),
    .rdata (rx_rdata)
  );

  urbri_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_head_r),
    .wdata (in_data),
    .re    (tx_re),
    .raddr (tx_tail_r),
    .rdata (tx_rdata)
  );

  assign out_valid_nxt = acc ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_head_r     <= '0;
      rx_tail_r     <= '0;
      tx_head_r     <= '0;
      tx_tail_r     <= '0;
      out_valid_r   <= 1'b0;
      rx_valid_r    <= 1'b0;
      ev_r          <= EV_NONE;
      rx_dropped_r  <= 1'b0;
      tx_valid_r    <= 1'b0;
      tx_accepted_r <= 1'b0;
      tx_idle_r     <= 1'b1;
      rx_count_r    <= '0;
      tx_count_r    <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (acc) begin
        rx_head_r     <= rx_head_nxt;
        rx_tail_r     <= rx_tail_nxt;
        tx_head_r     <= tx_head_nxt;
        tx_tail_r     <= tx_tail_nxt;
        rx_valid_r    <= rx_re;
        ev_r          <= ev_nxt;
        rx_dropped_r  <= rx_dropped_nxt;
        tx_valid_r    <= tx_re;
        tx_accepted_r <= tx_accepted_nxt;
        tx_idle_r     <= tx_head_nxt == tx_tail_nxt;
        rx_count_r    <= RX_CW'(rx_diff);
        tx_count_r    <= TX_CW'(tx_diff);
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_rx_byte     = rx_valid_r ? rx_rdata : 8'd0;
  assign out_rx_valid    = rx_valid_r;
  assign out_rt_event    = ev_r;
  assign out_rx_dropped  = rx_dropped_r;
  assign out_tx_byte     = tx_valid_r ? tx_rdata : 8'd0;
  assign out_tx_valid    = tx_valid_r;
  assign out_tx_accepted = tx_accepted_r;
  assign out_tx_idle     = tx_idle_r;
  assign out_rx_count    = rx_count_r;
  assign out_tx_count    = tx_count_r;

  `URBRI_ASSERT_NEXT(a_empty_read, acc && in_cmd == CMD_HOST_READ && rx_empty, !rx_valid_r, "read of empty receive ring returned a byte")
  `URBRI_ASSERT_NEXT(a_flush, acc && in_cmd == CMD_RX_FLUSH, rx_head_r == rx_tail_r, "flush left bytes in receive ring")
  `URBRI_ASSERT_IMPL(a_one_outcome, out_valid_r, $onehot0({rx_valid_r, rx_dropped_r, tx_valid_r, tx_accepted_r}), "more than one outcome flagged")
  `URBRI_ASSERT_IMPL(a_drop_no_event, out_valid_r && rx_dropped_r, ev_r == EV_NONE, "dropped byte also reported as event")

endmodule

@@ test/uart_ring_checker.sv @@
`timescale 1ns / 1ps

module uart_ring_checker
  import urbri_pkg::*;
#(
  parameter rt_codes_t RESET_CODES = '0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [2:0]        in_cmd,
  input  logic [7:0]        in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [7:0]        out_rx_byte,
  input  logic              out_rx_valid,
  input  logic [2:0]        out_rt_event,
  input  logic              out_rx_dropped,
  input  logic [7:0]        out_tx_byte,
  input  logic              out_tx_valid,
  input  logic              out_tx_accepted,
  input  logic              out_tx_idle,
  input  logic [6:0]        out_rx_count,
  input  logic [5:0]        out_tx_count,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [7:0]        cfg_wdata,
  output int                err_cnt,
  output int                pending_cnt
);

  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              rx_valid;
    rt_event_t         rt_event;
    logic              rx_dropped;
    logic [BYTE_W-1:0] tx_byte;
    logic              tx_valid;
    logic              tx_accepted;
    logic              tx_idle;
    logic [RX_CW-1:0]  rx_count;
    logic [TX_CW-1:0]  tx_count;
  } ring_result_t;

  rt_codes_t         codes;
  logic [BYTE_W-1:0] rx_mem [RX_DEPTH];
  logic [BYTE_W-1:0] tx_mem [TX_DEPTH];
  logic [RX_PW-1:0]  rx_wr, rx_rd;
  logic [TX_PW-1:0]  tx_wr, tx_rd;
  ring_result_t      expected_results [$];
  int                mismatches = 0;

  function automatic rt_event_t classify_byte(input logic [7:0] b);
    // first match wins when codes coincide
    if (b == codes.status_code) return EV_STATUS;
    if (b == codes.cycle_code) return EV_CYCLE;
    if (b == codes.hold_code) return EV_HOLD;
    if (b == codes.door_code) return EV_DOOR;
    if (b == codes.reset_code) return EV_RESET;
    return EV_NONE;
  endfunction

  function automatic ring_result_t predict_request(input logic [2:0] cmd,
                                                   input logic [7:0] data);
    ring_result_t     r;
    logic [RX_PW-1:0] rx_next;
    logic [TX_PW-1:0] tx_next;
    r = '0;
    rx_next = rx_wr + 1'b1;
    tx_next = tx_wr + 1'b1;
    case (cmd)
      CMD_LINE_RX: begin
        r.rt_event = classify_byte(data);
        if (r.rt_event == EV_NONE) begin
          if (rx_next != rx_rd) begin
            rx_mem[rx_wr] = data;
            rx_wr = rx_next;
          end else begin
            r.rx_dropped = 1'b1;
          end
        end
      end
      CMD_HOST_READ: begin
        if (rx_wr != rx_rd) begin
          r.rx_byte = rx_mem[rx_rd];
          r.rx_valid = 1'b1;
          rx_rd = rx_rd + 1'b1;
        end
      end
      CMD_HOST_WR: begin
        if (tx_next != tx_rd) begin
          tx_mem[tx_wr] = data;
          tx_wr = tx_next;
          r.tx_accepted = 1'b1;
        end
      end
      CMD_TX_READY: begin
        if (tx_wr != tx_rd) begin
          r.tx_byte = tx_mem[tx_rd];
          r.tx_valid = 1'b1;
          tx_rd = tx_rd + 1'b1;
        end
      end
      CMD_RX_FLUSH: rx_rd = rx_wr;
      default: ;
    endcase
    r.tx_idle = (tx_wr == tx_rd);
    r.rx_count = RX_CW'(rx_wr - rx_rd);
    r.tx_count = TX_CW'(tx_wr - tx_rd);
    return r;
  endfunction

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      if (mismatches < MAX_SHOWN)
        $display("mismatch on %s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    ring_result_t want;
    if (!rst_n) begin
      codes = RESET_CODES;
      rx_wr = '0;
      rx_rd = '0;
      tx_wr = '0;
      tx_rd = '0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          if (mismatches < MAX_SHOWN)
            $display("mismatch: result with no request outstanding");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("rx_byte", want.rx_byte, out_rx_byte);
          check_field("rx_valid", want.rx_valid, out_rx_valid);
          check_field("rt_event", want.rt_event, out_rt_event);
          check_field("rx_dropped", want.rx_dropped, out_rx_dropped);
          check_field("tx_byte", want.tx_byte, out_tx_byte);
          check_field("tx_valid", want.tx_valid, out_tx_valid);
          check_field("tx_accepted", want.tx_accepted, out_tx_accepted);
          check_field("tx_idle", want.tx_idle, out_tx_idle);
          check_field("rx_count", want.rx_count, out_rx_count);
          check_field("tx_count", want.tx_count, out_tx_count);
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_STATUS: codes.status_code = cfg_wdata;
          REG_CYCLE:  codes.cycle_code = cfg_wdata;
          REG_HOLD:   codes.hold_code = cfg_wdata;
          REG_DOOR:   codes.door_code = cfg_wdata;
          REG_RESET:  codes.reset_code = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_results.push_back(predict_request(in_cmd, in_data));
    end
    pending_cnt <= expected_results.size();
    err_cnt <= mismatches;
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import urbri_pkg::*;

  localparam rt_codes_t RESET_CODES = '{status_code: 8'd63, cycle_code: 8'd126,
                                        hold_code: 8'd33, door_code: 8'd64,
                                        reset_code: 8'd24};
  localparam logic [2:0]        CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0]        CMD_SPARE_LAST  = 3'd7;
  localparam logic [CFG_IW-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IW-1:0] REG_SPARE_LAST  = 3'd7;
  localparam int RANDOM_REQUESTS = 1200;
  localparam int BLOCK_LEN       = 100;
  localparam int TAIL_LEN        = 100;
  localparam int CYCLE_LIMIT     = 200000;

  typedef enum int {MIX, FILL_RX, DRAIN_RX, FILL_TX, DRAIN_TX} traffic_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [2:0]        in_cmd = '0;
  logic [7:0]        in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        out_rx_byte;
  logic              out_rx_valid;
  logic [2:0]        out_rt_event;
  logic              out_rx_dropped;
  logic [7:0]        out_tx_byte;
  logic              out_tx_valid;
  logic              out_tx_accepted;
  logic              out_tx_idle;
  logic [6:0]        out_rx_count;
  logic [5:0]        out_tx_count;
  logic              cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [7:0]        cfg_wdata = '0;

  int        err_cnt;
  int        pending_cnt;
  int        idle_pct = 0;
  int        out_hold = 0;
  int        cycles = 0;
  rt_codes_t cur_codes = RESET_CODES;

  uart_ring_buffers_realtime_intercept u_dut (.*);

  uart_ring_checker #(.RESET_CODES(RESET_CODES)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side stalls in random bursts
  always @(posedge clk) begin
    if (out_hold != 0) begin
      out_ready <= 1'b0;
      out_hold <= out_hold - 1;
    end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      out_ready <= 1'b0;
      out_hold <= $urandom_range(4);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_request(input logic [2:0] c, input logic [7:0] d);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= c;
    in_data <= d;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and wait until every result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
  endtask

  task automatic put_reg(input logic [CFG_IW-1:0] idx, input logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  task automatic load_codes(input rt_codes_t c);
    put_reg(REG_STATUS, c.status_code);
    put_reg(REG_CYCLE, c.cycle_code);
    put_reg(REG_HOLD, c.hold_code);
    put_reg(REG_DOOR, c.door_code);
    put_reg(REG_RESET, c.reset_code);
    // unmapped indexes must leave the codes alone
    for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++)
      put_reg(CFG_IW'(i), 8'($urandom));
    cfg_we <= 1'b0;
    cur_codes = c;
  endtask

  function automatic rt_codes_t random_codes();
    rt_codes_t c;
    c.status_code = 8'($urandom);
    c.cycle_code = 8'($urandom);
    c.hold_code = 8'($urandom);
    c.door_code = 8'($urandom);
    c.reset_code = 8'($urandom);
    return c;
  endfunction

  function automatic logic [2:0] pick_cmd(input traffic_t mode);
    int r;
    r = $urandom_range(99);
    case (mode)
      FILL_RX:  return r < 90 ? CMD_LINE_RX : (r < 95 ? CMD_HOST_WR : CMD_TX_READY);
      DRAIN_RX: return r < 80 ? CMD_HOST_READ : (r < 90 ? CMD_LINE_RX :
                       (r < 95 ? CMD_RX_FLUSH : 3'($urandom_range(CMD_SPARE_LAST,
                                                                  CMD_SPARE_FIRST))));
      FILL_TX:  return r < 90 ? CMD_HOST_WR : (r < 95 ? CMD_LINE_RX : CMD_HOST_READ);
      DRAIN_TX: return r < 85 ? CMD_TX_READY : (r < 95 ? CMD_HOST_WR : CMD_HOST_READ);
      default: begin
        if (r < 35) return CMD_LINE_RX;
        if (r < 60) return CMD_HOST_READ;
        if (r < 80) return CMD_HOST_WR;
        if (r < 95) return CMD_TX_READY;
        if (r < 97) return CMD_RX_FLUSH;
        return 3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
      end
    endcase
  endfunction

  function automatic logic [7:0] pick_data(input logic [2:0] c);
    int r;
    r = $urandom_range(99);
    // steer some line bytes onto the live realtime codes
    if (c == CMD_LINE_RX && r < 15) begin
      case ($urandom_range(4))
        0: return cur_codes.status_code;
        1: return cur_codes.cycle_code;
        2: return cur_codes.hold_code;
        3: return cur_codes.door_code;
        default: return cur_codes.reset_code;
      endcase
    end
    if (r < 20) return (r < 18) ? 8'h00 : 8'hFF;
    return 8'($urandom);
  endfunction

  initial begin
    int       sent;
    int       blk;
    int       len;
    traffic_t mode;
    logic [2:0] c;
    rt_codes_t  cfg;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty rings, reset codes, ordering and flush
    send_request(CMD_HOST_READ, 8'h00);
    send_request(CMD_TX_READY, 8'h00);
    send_request(CMD_LINE_RX, 8'h00);
    send_request(CMD_LINE_RX, 8'hFF);
    send_request(CMD_LINE_RX, RESET_CODES.status_code);
    send_request(CMD_LINE_RX, RESET_CODES.cycle_code);
    send_request(CMD_LINE_RX, RESET_CODES.hold_code);
    send_request(CMD_LINE_RX, RESET_CODES.door_code);
    send_request(CMD_LINE_RX, RESET_CODES.reset_code);
    send_request(CMD_HOST_WR, 8'h00);
    send_request(CMD_HOST_WR, 8'hFF);
    send_request(CMD_HOST_READ, 8'h00);
    send_request(CMD_HOST_READ, 8'h00);
    send_request(CMD_HOST_READ, 8'h00);
    send_request(CMD_TX_READY, 8'h00);
    send_request(CMD_TX_READY, 8'h00);
    send_request(CMD_LINE_RX, 8'hA5);
    send_request(CMD_RX_FLUSH, 8'h00);
    send_request(CMD_SPARE_FIRST, 8'hFF);
    send_request(CMD_SPARE_LAST, 8'h5A);

    // all codes equal: status wins
    drain_results();
    load_codes('{status_code: 8'h00, cycle_code: 8'h00, hold_code: 8'h00,
                 door_code: 8'h00, reset_code: 8'h00});
    send_request(CMD_LINE_RX, 8'h00);

    // pairs equal: cycle over hold, door over reset
    drain_results();
    load_codes('{status_code: 8'h01, cycle_code: 8'hFF, hold_code: 8'hFF,
                 door_code: 8'h80, reset_code: 8'h80});
    send_request(CMD_LINE_RX, 8'hFF);
    send_request(CMD_LINE_RX, 8'h80);
    send_request(CMD_LINE_RX, 8'h01);

    sent = 0;
    blk = 0;
    while (sent < RANDOM_REQUESTS - TAIL_LEN) begin
      mode = traffic_t'(blk % 5);
      len = (mode == FILL_RX) ? 2 * BLOCK_LEN : BLOCK_LEN;
      drain_results();
      case (blk % 3)
        0: idle_pct <= 0;
        1: idle_pct <= 25;
        default: idle_pct <= 50;
      endcase
      case (blk % 4)
        0: cfg = random_codes();
        1: cfg = RESET_CODES;
        2: cfg = '{status_code: 8'h00, cycle_code: 8'hFF, hold_code: 8'h00,
                   door_code: 8'hFF, reset_code: 8'h7F};
        default: begin
          cfg = random_codes();
          cfg.reset_code = cfg.status_code;
          cfg.door_code = cfg.cycle_code;
        end
      endcase
      load_codes(cfg);
      for (int i = 0; i < len; i++) begin
        c = pick_cmd(mode);
        send_request(c, pick_data(c));
      end
      sent += len;
      blk++;
    end

    // closing stretch at full rate on both sides
    drain_results();
    idle_pct <= 0;
    load_codes(RESET_CODES);
    for (int i = 0; i < TAIL_LEN; i++) begin
      c = pick_cmd(MIX);
      send_request(c, pick_data(c));
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (err_cnt == 0 && pending_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
